// File: rtl/core/lut3d_pkg.sv
`timescale 1ns / 1ps

package lut3d_pkg;

   // default sizes of the lattice and of the table memory
   localparam int unsigned DEF_MAX_GRID    = 33;
   localparam int unsigned DEF_LUT_ENTRIES = 35937;

   // field widths
   localparam int unsigned GRID_W  = 6;
   localparam int unsigned COMP_W  = 17;
   localparam int unsigned ADDR_IN_W = 16;
   localparam int unsigned ENT_W   = 18;
   localparam int unsigned ENTRY_W = 3 * ENT_W;
   localparam int unsigned FRAC_W  = 17;
   localparam int unsigned W1_W    = 33;
   localparam int unsigned ACC_W   = 40;

   // shared multiplier operand widths
   localparam int unsigned MUL_A_W = 34;
   localparam int unsigned MUL_B_W = 19;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [GRID_W-1:0] GRID_RESET = 6'd33;
   localparam logic [GRID_W-1:0] GRID_MIN   = 6'd2;
   localparam logic [FRAC_W-1:0] ONE_Q16    = 17'h10000;
   localparam logic signed [ACC_W:0] ROUND_BIAS = 41'sd32768;
   localparam int SAT_MIN = -131072;
   localparam int SAT_MAX = 131071;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // sequencer step codes
   localparam int unsigned STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
   localparam logic [STEP_W-1:0] AXIS_LAST  = 3'd2;
   localparam logic [STEP_W-1:0] BASE_GG    = 3'd0;
   localparam logic [STEP_W-1:0] BASE_ROW   = 3'd1;
   localparam logic [STEP_W-1:0] BASE_PLANE = 3'd2;
   localparam logic [STEP_W-1:0] STEP_W1    = 3'd0;
   localparam logic [STEP_W-1:0] STEP_WT    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_RED   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_GREEN = 3'd3;
   localparam logic [STEP_W-1:0] STEP_BLUE  = 3'd4;

   localparam int unsigned CORNER_W = 3;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_AXIS   = 5'b00010,
      ST_BASE   = 5'b00100,
      ST_CORNER = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // table memory strobes
   typedef struct packed {
      logic write;
      logic read;
   } store_ctrl_type;

   // round half up on the Q16 point, then clamp to signed 18 bits
   function automatic logic [ENT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]    biased;
      logic signed [ACC_W-16:0] r;
      biased = {acc[ACC_W-1], acc} + ROUND_BIAS;
      r = biased[ACC_W:16];
      priority if (r < SAT_MIN) begin
         return ENT_W'(SAT_MIN);
      end else if (r > SAT_MAX) begin
         return ENT_W'(SAT_MAX);
      end else begin
         return r[ENT_W-1:0];
      end
   endfunction

endpackage

// File: rtl/core/lut3d_store.sv
`timescale 1ns / 1ps

module lut3d_store #(
   parameter int unsigned DEPTH = lut3d_pkg::DEF_LUT_ENTRIES,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  lut3d_pkg::store_ctrl_type     ctrl,
   input  logic [AW-1:0]                 addr,
   input  logic [lut3d_pkg::ENTRY_W-1:0] wdata,
   output logic [lut3d_pkg::ENTRY_W-1:0] rdata
);
   import lut3d_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   // single port table, registered read
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         mem[addr] <= wdata;
      end
      if (ctrl.read) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/lut3d_trilinear_apply_top.sv
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_ready  | kind, rgb pixel, eof, table address and entry
// rsp      | out       | rsp_valid/rsp_ready  | interpolated rgb, frame_done
// csr      | in        | csr_valid/csr_ready  | grid_size
//
// a load item is taken while idle and writes the table memory directly.
// a pixel item passes 3 axis steps, 3 address steps, 5 steps for each of
// the 8 corners and 1 rounding step on its way to the result register; the
// next item is taken in the cycle after, so only one pixel is in work at a time.
// all multiplies go through one 34x19 multiplier, paced by a step sequencer.
// synchronous reset clears the sequencer, the result valid and grid_size (33);
// table contents stay undefined until loaded. a stalled result waits in its
// register and the sequencer holds at the rounding step until it is free.

module lut3d_trilinear_apply_top #(
   parameter int unsigned MAX_GRID    = lut3d_pkg::DEF_MAX_GRID,
   parameter int unsigned LUT_ENTRIES = lut3d_pkg::DEF_LUT_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lut3d_pkg::GRID_W-1:0]        csr_grid_size,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_red,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_green,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_blue,
   input  logic                                req_end_of_frame,
   input  logic [lut3d_pkg::ADDR_IN_W-1:0]     req_table_address,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_red,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_green,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_blue,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_red,
   output logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_green,
   output logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_blue,
   output logic                                rsp_frame_done
);
   import lut3d_pkg::*;

   localparam int unsigned GW  = $clog2(MAX_GRID + 1);
   localparam int unsigned TW  = COMP_W + GW;
   localparam int unsigned IRW = TW - 16;
   localparam int unsigned GGW = $clog2(MAX_GRID * MAX_GRID + 1);
   localparam int unsigned CAW = $clog2(MAX_GRID * MAX_GRID * MAX_GRID);
   localparam int unsigned AW  = $clog2(LUT_ENTRIES);

   // control state
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CORNER_W-1:0]   corner_ff, corner_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GRID_W-1:0]     grid_ff, grid_in;

   // datapath registers
   logic [COMP_W-1:0]     comp_ff [0:2];
   logic [COMP_W-1:0]     comp_in [0:2];
   logic                  eof_ff, eof_in;
   logic [GW-1:0]         idx_ff [0:2];
   logic [GW-1:0]         idx_in [0:2];
   logic [FRAC_W-1:0]     frac_ff [0:2];
   logic [FRAC_W-1:0]     frac_in [0:2];
   logic [GGW-1:0]        gg_ff, gg_in;
   logic [CAW-1:0]        base_ff, base_in;
   logic [W1_W-1:0]       w1_ff, w1_in;
   logic [FRAC_W-1:0]     wt_ff, wt_in;
   logic                  zero_ff, zero_in;
   logic signed [ACC_W-1:0] acc_ff [0:2];
   logic signed [ACC_W-1:0] acc_in [0:2];
   logic [ENT_W-1:0]      out_red_ff, out_red_in;
   logic [ENT_W-1:0]      out_green_ff, out_green_in;
   logic [ENT_W-1:0]      out_blue_ff, out_blue_in;
   logic                  done_ff, done_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   // helpers
   logic [GW-1:0]         grid_eff, grid_m1, grid_m2;
   logic [IRW-1:0]        t_idx;
   logic [15:0]           t_frac;
   logic [FRAC_W-1:0]     w_r_sel, w_g_sel, w_b_sel;
   logic [CAW-1:0]        corner_addr;
   logic                  corner_ok, load_ok;
   logic [ENTRY_W-1:0]    rdata;
   logic [ENT_W-1:0]      ent_red, ent_green, ent_blue;
   store_ctrl_type        store_ctrl;
   logic [AW-1:0]         store_addr;
   logic                  pixel_take, load_take;

   // effective grid size, clamped to the lattice that fits
   always_comb begin
      priority if (grid_ff < GRID_MIN) begin
         grid_eff = GW'(GRID_MIN);
      end else if (int'(grid_ff) > MAX_GRID) begin
         grid_eff = GW'(MAX_GRID);
      end else begin
         grid_eff = GW'(grid_ff);
      end
   end
   assign grid_m1 = grid_eff - GW'(1);
   assign grid_m2 = grid_eff - GW'(2);

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign pixel_take = req_valid && req_ready && (req_kind == KIND_PIXEL);
   assign load_take  = req_valid && req_ready && (req_kind == KIND_LOAD);
   assign load_ok    = int'(req_table_address) < LUT_ENTRIES;

   // corner weights and corner address
   assign w_r_sel = corner_ff[0] ? frac_ff[0] : ONE_Q16 - frac_ff[0];
   assign w_g_sel = corner_ff[1] ? frac_ff[1] : ONE_Q16 - frac_ff[1];
   assign w_b_sel = corner_ff[2] ? frac_ff[2] : ONE_Q16 - frac_ff[2];
   assign corner_addr = base_ff + CAW'(corner_ff[0])
                      + (corner_ff[1] ? CAW'(grid_eff) : '0)
                      + (corner_ff[2] ? CAW'(gg_ff) : '0);
   assign corner_ok = int'(corner_addr) < LUT_ENTRIES;

   // corners beyond the table read as zero
   assign ent_red   = zero_ff ? '0 : rdata[ENT_W-1:0];
   assign ent_green = zero_ff ? '0 : rdata[2*ENT_W-1:ENT_W];
   assign ent_blue  = zero_ff ? '0 : rdata[3*ENT_W-1:2*ENT_W];

   // axis split of the product c*(grid-1)
   assign t_idx  = mul_p[TW-1:16];
   assign t_frac = mul_p[15:0];

   assign mul_p = mul_a * mul_b;

   // table memory access
   always_comb begin
      store_ctrl.write = load_take && load_ok;
      store_ctrl.read  = (state_ff == ST_CORNER) && (step_ff == STEP_W1) && corner_ok;
      store_addr = (state_ff == ST_IDLE) ? AW'(req_table_address) : AW'(corner_addr);
   end

   lut3d_store #(
      .DEPTH (LUT_ENTRIES)
   ) u_store (
      .clock (clock),
      .ctrl  (store_ctrl),
      .addr  (store_addr),
      .wdata ({req_table_blue, req_table_green, req_table_red}),
      .rdata (rdata)
   );

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      corner_in    = corner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      grid_in      = csr_valid ? csr_grid_size : grid_ff;
      comp_in      = comp_ff;
      eof_in       = eof_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      gg_in        = gg_ff;
      base_in      = base_ff;
      w1_in        = w1_ff;
      wt_in        = wt_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      done_in      = done_ff;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pixel_take) begin
               comp_in[0] = req_in_red;
               comp_in[1] = req_in_green;
               comp_in[2] = req_in_blue;
               eof_in     = req_end_of_frame;
               acc_in[0]  = '0;
               acc_in[1]  = '0;
               acc_in[2]  = '0;
               step_in    = STEP_FIRST;
               state_in   = ST_AXIS;
            end
         end

         // one colour axis per step: index and fraction
         ST_AXIS: begin
            mul_a = MUL_A_W'(comp_ff[step_ff[1:0]]);
            mul_b = MUL_B_W'(grid_m1);
            if (int'(t_idx) >= int'(grid_m1)) begin
               idx_in[step_ff[1:0]]  = grid_m2;
               frac_in[step_ff[1:0]] = ONE_Q16;
            end else begin
               idx_in[step_ff[1:0]]  = t_idx[GW-1:0];
               frac_in[step_ff[1:0]] = {1'b0, t_frac};
            end
            if (step_ff == AXIS_LAST) begin
               step_in  = STEP_FIRST;
               state_in = ST_BASE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end

         // base address r + g*grid + b*grid*grid
         ST_BASE: begin
            unique case (step_ff)
               BASE_GG: begin
                  mul_a   = MUL_A_W'(grid_eff);
                  mul_b   = MUL_B_W'(grid_eff);
                  gg_in   = mul_p[GGW-1:0];
                  step_in = BASE_ROW;
               end
               BASE_ROW: begin
                  mul_a   = MUL_A_W'(idx_ff[1]);
                  mul_b   = MUL_B_W'(grid_eff);
                  base_in = CAW'(idx_ff[0]) + mul_p[CAW-1:0];
                  step_in = BASE_PLANE;
               end
               BASE_PLANE: begin
                  mul_a     = MUL_A_W'(gg_ff);
                  mul_b     = MUL_B_W'(idx_ff[2]);
                  base_in   = base_ff + mul_p[CAW-1:0];
                  corner_in = '0;
                  step_in   = STEP_W1;
                  state_in  = ST_CORNER;
               end
               default: begin
                  step_in = BASE_GG;
               end
            endcase
         end

         // per corner: two weight products, then one product per channel
         ST_CORNER: begin
            unique case (step_ff)
               STEP_W1: begin
                  mul_a   = MUL_A_W'(w_r_sel);
                  mul_b   = MUL_B_W'(w_g_sel);
                  w1_in   = mul_p[W1_W-1:0];
                  zero_in = !corner_ok;
                  step_in = STEP_WT;
               end
               STEP_WT: begin
                  mul_a   = MUL_A_W'(w1_ff);
                  mul_b   = MUL_B_W'(w_b_sel);
                  wt_in   = mul_p[32+FRAC_W-1:32];
                  step_in = STEP_RED;
               end
               STEP_RED: begin
                  mul_a     = MUL_A_W'(wt_ff);
                  mul_b     = {ent_red[ENT_W-1], ent_red};
                  acc_in[0] = acc_ff[0] + ACC_W'(mul_p);
                  step_in   = STEP_GREEN;
               end
               STEP_GREEN: begin
                  mul_a     = MUL_A_W'(wt_ff);
                  mul_b     = {ent_green[ENT_W-1], ent_green};
                  acc_in[1] = acc_ff[1] + ACC_W'(mul_p);
                  step_in   = STEP_BLUE;
               end
               STEP_BLUE: begin
                  mul_a     = MUL_A_W'(wt_ff);
                  mul_b     = {ent_blue[ENT_W-1], ent_blue};
                  acc_in[2] = acc_ff[2] + ACC_W'(mul_p);
                  step_in   = STEP_W1;
                  if (corner_ff == CORNER_LAST) begin
                     state_in = ST_FINISH;
                  end else begin
                     corner_in = corner_ff + CORNER_W'(1);
                  end
               end
               default: begin
                  step_in = STEP_W1;
               end
            endcase
         end

         // round into the result register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_red_in   = round_sat(acc_ff[0]);
               out_green_in = round_sat(acc_ff[1]);
               out_blue_in  = round_sat(acc_ff[2]);
               done_in      = eof_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FIRST;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         grid_ff      <= GRID_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         grid_ff      <= grid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      comp_ff      <= comp_in;
      eof_ff       <= eof_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      gg_ff        <= gg_in;
      base_ff      <= base_in;
      w1_ff        <= w1_in;
      wt_ff        <= wt_in;
      zero_ff      <= zero_in;
      acc_ff       <= acc_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      done_ff      <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = out_red_ff;
   assign rsp_out_green  = out_green_ff;
   assign rsp_out_blue   = out_blue_ff;
   assign rsp_frame_done = done_ff;

   // checks
   a_pixel_starts: assert property (@(posedge clock) disable iff (reset)
      pixel_take |=> state_ff == ST_AXIS)
      else $error("pixel item did not start the axis steps");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_take |=> state_ff == ST_IDLE)
      else $error("load item left the idle state");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(store_ctrl.write && store_ctrl.read))
      else $error("table written and read in one cycle");

   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORNER |-> step_ff <= STEP_BLUE)
      else $error("corner step out of range");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid && !rsp_ready)
      |=> (state_ff == ST_FINISH && rsp_valid))
      else $error("pending result overwritten");

endmodule

// File: bench/lut3d_apply_checker.sv
`timescale 1ns / 1ps

module lut3d_apply_checker #(
   parameter int unsigned MAX_GRID    = lut3d_pkg::DEF_MAX_GRID,
   parameter int unsigned LUT_ENTRIES = lut3d_pkg::DEF_LUT_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [lut3d_pkg::GRID_W-1:0]        csr_grid_size,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_kind,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_red,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_green,
   input  logic [lut3d_pkg::COMP_W-1:0]        req_in_blue,
   input  logic                                req_end_of_frame,
   input  logic [lut3d_pkg::ADDR_IN_W-1:0]     req_table_address,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_red,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_green,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  req_table_blue,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_red,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_green,
   input  logic signed [lut3d_pkg::ENT_W-1:0]  rsp_out_blue,
   input  logic                                rsp_frame_done,
   output int                                  fail_count,
   output int                                  outstanding
);
   import lut3d_pkg::*;

   typedef struct packed {
      logic signed [ENT_W-1:0] red;
      logic signed [ENT_W-1:0] green;
      logic signed [ENT_W-1:0] blue;
      logic                    frame_done;
   } pixel_out_type;

   // mirror of the colour table: red in the low bits, blue in the high bits
   logic [ENTRY_W-1:0] lut_mirror [LUT_ENTRIES];
   logic [GRID_W-1:0]  grid_shadow = GRID_RESET;
   pixel_out_type      expected_pixels [$];
   pixel_out_type      want_pixel;
   int                 fails = 0;

   initial begin
      foreach (lut_mirror[i]) lut_mirror[i] = '0;
   end

   // lattice index and fraction along one colour axis
   function automatic void split_axis(input logic [COMP_W-1:0] comp, input longint gs,
                                      output longint idx, output longint frac);
      longint t;
      t = longint'(comp) * (gs - 1);
      idx = t >>> 16;
      frac = t & 64'hFFFF;
      // top of the axis uses the last cell at full weight
      if (idx >= gs - 1) begin
         idx = gs - 2;
         frac = longint'(ONE_Q16);
      end
   endfunction

   // round half up on the q16 point and clamp to signed 18 bits
   function automatic logic signed [ENT_W-1:0] clamp_q16(input longint acc);
      longint r;
      r = (acc + 32768) >>> 16;
      if (r < SAT_MIN) begin
         r = SAT_MIN;
      end else if (r > SAT_MAX) begin
         r = SAT_MAX;
      end
      return r[ENT_W-1:0];
   endfunction

   // trilinear blend of the eight lattice corners around one pixel
   function automatic pixel_out_type interpolate_pixel(input logic [COMP_W-1:0] red,
                                                       input logic [COMP_W-1:0] green,
                                                       input logic [COMP_W-1:0] blue,
                                                       input logic eof);
      longint gs, ir, ig, ib, fr, fg, fb, w, addr;
      longint wr [2];
      longint wg [2];
      longint wb [2];
      longint acc [3];
      logic [ENTRY_W-1:0] e;
      pixel_out_type res;
      gs = grid_shadow;
      if (gs < GRID_MIN) gs = GRID_MIN;
      if (gs > MAX_GRID) gs = MAX_GRID;
      split_axis(red, gs, ir, fr);
      split_axis(green, gs, ig, fg);
      split_axis(blue, gs, ib, fb);
      wr[0] = longint'(ONE_Q16) - fr;
      wr[1] = fr;
      wg[0] = longint'(ONE_Q16) - fg;
      wg[1] = fg;
      wb[0] = longint'(ONE_Q16) - fb;
      wb[1] = fb;
      acc[0] = 0;
      acc[1] = 0;
      acc[2] = 0;
      for (int k = 0; k < 8; k++) begin
         w = (wr[k & 1] * wg[(k >> 1) & 1] * wb[(k >> 2) & 1]) >>> 32;
         addr = (ir + (k & 1)) + (ig + ((k >> 1) & 1)) * gs
                + (ib + ((k >> 2) & 1)) * gs * gs;
         // corners past the end of the table read as zero
         e = (addr < LUT_ENTRIES) ? lut_mirror[addr] : '0;
         for (int ch = 0; ch < 3; ch++) begin
            acc[ch] += w * longint'($signed(e[ch*ENT_W +: ENT_W]));
         end
      end
      res.red = clamp_q16(acc[0]);
      res.green = clamp_q16(acc[1]);
      res.blue = clamp_q16(acc[2]);
      res.frame_done = eof;
      return res;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         grid_shadow = GRID_RESET;
      end else begin
         // grid size write
         if (csr_valid && csr_ready) begin
            grid_shadow = csr_grid_size;
         end
         // result item against the oldest pixel still owed
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result item with no pixel outstanding");
               fails++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               compare_field("out_red", want_pixel.red, rsp_out_red);
               compare_field("out_green", want_pixel.green, rsp_out_green);
               compare_field("out_blue", want_pixel.blue, rsp_out_blue);
               compare_field("frame_done", want_pixel.frame_done, rsp_frame_done);
            end
         end
         // input item: a load updates the mirror, a pixel queues its colour
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               if (req_table_address < LUT_ENTRIES) begin
                  lut_mirror[req_table_address] = {req_table_blue, req_table_green,
                                                   req_table_red};
               end
            end else begin
               expected_pixels.push_back(interpolate_pixel(req_in_red, req_in_green,
                                                           req_in_blue, req_end_of_frame));
            end
         end
      end
      fail_count <= fails;
      outstanding <= expected_pixels.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import lut3d_pkg::*;

   localparam int unsigned MAX_GRID    = DEF_MAX_GRID;
   localparam int unsigned LUT_ENTRIES = DEF_LUT_ENTRIES;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int PHASE_ITEMS   = 60;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [GRID_W-1:0]        csr_grid_size = GRID_RESET;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = KIND_LOAD;
   logic [COMP_W-1:0]        req_in_red = '0;
   logic [COMP_W-1:0]        req_in_green = '0;
   logic [COMP_W-1:0]        req_in_blue = '0;
   logic                     req_end_of_frame = 1'b0;
   logic [ADDR_IN_W-1:0]     req_table_address = '0;
   logic signed [ENT_W-1:0]  req_table_red = '0;
   logic signed [ENT_W-1:0]  req_table_green = '0;
   logic signed [ENT_W-1:0]  req_table_blue = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [ENT_W-1:0]  rsp_out_red;
   logic signed [ENT_W-1:0]  rsp_out_green;
   logic signed [ENT_W-1:0]  rsp_out_blue;
   logic                     rsp_frame_done;

   int fail_count;
   int outstanding;
   int send_idle = 31;
   int recv_idle = 74;
   int cycles = 0;
   // grid size in force and the table entries that hold data
   int unsigned grid_now;
   bit written [LUT_ENTRIES];

   always #5 clock = ~clock;

   lut3d_trilinear_apply_top #(
      .MAX_GRID(MAX_GRID),
      .LUT_ENTRIES(LUT_ENTRIES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_grid_size(csr_grid_size),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_in_red(req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue(req_in_blue),
      .req_end_of_frame(req_end_of_frame),
      .req_table_address(req_table_address),
      .req_table_red(req_table_red),
      .req_table_green(req_table_green),
      .req_table_blue(req_table_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_frame_done(rsp_frame_done)
   );

   lut3d_apply_checker #(
      .MAX_GRID(MAX_GRID),
      .LUT_ENTRIES(LUT_ENTRIES)
   ) colour_check (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_grid_size(csr_grid_size),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_in_red(req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue(req_in_blue),
      .req_end_of_frame(req_end_of_frame),
      .req_table_address(req_table_address),
      .req_table_red(req_table_red),
      .req_table_green(req_table_green),
      .req_table_blue(req_table_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_frame_done(rsp_frame_done),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lut3d_trilinear_apply_top verification failed");
         $finish;
      end
   end

   // grid size as the block uses it
   function automatic int unsigned eff_grid(input logic [GRID_W-1:0] value);
      int unsigned g;
      g = int'(value);
      if (g < int'(GRID_MIN)) g = int'(GRID_MIN);
      if (g > MAX_GRID) g = MAX_GRID;
      return g;
   endfunction

   // lattice cell of one component at the grid size in force
   function automatic int unsigned cell_of(input logic [COMP_W-1:0] comp);
      int unsigned t;
      int unsigned idx;
      t = int'(comp) * (grid_now - 1);
      idx = t >> 16;
      if (idx >= grid_now - 1) idx = grid_now - 2;
      return idx;
   endfunction

   // present one item after a random gap and hold it until taken
   task automatic offer_item(input logic kind, input logic [COMP_W-1:0] red,
                             input logic [COMP_W-1:0] green, input logic [COMP_W-1:0] blue,
                             input logic eof, input logic [ADDR_IN_W-1:0] addr,
                             input logic signed [ENT_W-1:0] t_red,
                             input logic signed [ENT_W-1:0] t_green,
                             input logic signed [ENT_W-1:0] t_blue);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_in_red <= red;
      req_in_green <= green;
      req_in_blue <= blue;
      req_end_of_frame <= eof;
      req_table_address <= addr;
      req_table_red <= t_red;
      req_table_green <= t_green;
      req_table_blue <= t_blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // table load item, pixel fields carry noise
   task automatic offer_load(input logic [ADDR_IN_W-1:0] addr,
                             input logic signed [ENT_W-1:0] t_red,
                             input logic signed [ENT_W-1:0] t_green,
                             input logic signed [ENT_W-1:0] t_blue);
      if (int'(addr) < LUT_ENTRIES) written[addr] = 1'b1;
      offer_item(KIND_LOAD, COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
                 1'($urandom), addr, t_red, t_green, t_blue);
   endtask

   // pixel item, table fields carry noise; corners never loaded get an entry first
   task automatic offer_pixel(input logic [COMP_W-1:0] red, input logic [COMP_W-1:0] green,
                              input logic [COMP_W-1:0] blue, input logic eof);
      int unsigned cr, cg, cb, addr;
      cr = cell_of(red);
      cg = cell_of(green);
      cb = cell_of(blue);
      for (int k = 0; k < 8; k++) begin
         addr = (cr + (k & 1)) + (cg + ((k >> 1) & 1)) * grid_now
                + (cb + ((k >> 2) & 1)) * grid_now * grid_now;
         if (addr < LUT_ENTRIES && !written[addr]) begin
            offer_load(ADDR_IN_W'(addr), ENT_W'($urandom), ENT_W'($urandom),
                       ENT_W'($urandom));
         end
      end
      offer_item(KIND_PIXEL, red, green, blue, eof, ADDR_IN_W'($urandom),
                 ENT_W'($urandom), ENT_W'($urandom), ENT_W'($urandom));
   endtask

   // stop sending, wait for every owed pixel, then let the block go quiet
   task automatic settle(input int guard);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (guard) @(posedge clock);
   endtask

   task automatic write_grid(input logic [GRID_W-1:0] value);
      settle(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_grid_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      grid_now = eff_grid(value);
   endtask

   // colour component in the first or last cell, at the ends or just past full scale
   function automatic logic [COMP_W-1:0] pick_component(input int unsigned gs);
      int unsigned span;
      span = 65535 / (gs - 1);
      case ($urandom_range(7))
         0: return '0;
         1: return ONE_Q16;
         2: return ONE_Q16 - COMP_W'(1);
         3: return COMP_W'(((gs - 2) * 65536) / (gs - 1));
         4: return '1;
         5, 6: return COMP_W'($urandom_range(span));
         default: return ONE_Q16 - COMP_W'($urandom_range(span));
      endcase
   endfunction

   initial begin
      int unsigned gs;
      int unsigned cube;
      logic [GRID_W-1:0] plan [10];
      plan = '{6'd2, 6'd0, 6'd1, 6'd33, 6'd63, 6'd34, 6'd5, 6'd17, 6'd2, 6'd2};
      plan[8] = GRID_W'($urandom_range(33, 2));
      plan[9] = GRID_W'($urandom_range(63));
      grid_now = eff_grid(GRID_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // extreme entries at both ends of the table
      offer_load('0, ENT_W'(SAT_MAX), ENT_W'(SAT_MIN), '0);
      offer_load(ADDR_IN_W'(LUT_ENTRIES - 1), ENT_W'(SAT_MIN), ENT_W'(SAT_MAX), '1);

      // directed pixels at the reset grid size
      offer_pixel('0, '0, '0, 1'b0);
      offer_pixel(ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
      offer_pixel(ONE_Q16 - COMP_W'(1), ONE_Q16 - COMP_W'(1), ONE_Q16 - COMP_W'(1), 1'b0);
      offer_pixel(ONE_Q16, '0, 17'd32768, 1'b1);
      offer_pixel(17'd1, ONE_Q16 - COMP_W'(1), 17'd2048, 1'b0);
      offer_pixel(17'd2048, 17'd2048, 17'd2048, 1'b0);
      // loads past the end of the table are dropped
      offer_load(16'hFFFF, ENT_W'(SAT_MIN), ENT_W'(SAT_MIN), ENT_W'(SAT_MIN));
      offer_load(ADDR_IN_W'(LUT_ENTRIES), ENT_W'(SAT_MAX), '0, '0);
      offer_pixel(ONE_Q16, ONE_Q16, ONE_Q16, 1'b0);
      // rewrite a corner and read it straight back
      offer_load('0, '1, ENT_W'(1), ENT_W'(SAT_MIN));
      offer_pixel('0, '0, '0, 1'b1);
      offer_load(16'd1, ENT_W'(SAT_MAX), ENT_W'(SAT_MIN), ENT_W'(SAT_MAX));
      offer_pixel(17'd1024, '0, '0, 1'b0);

      // one phase per grid size, idling pattern changing as it goes
      for (int p = 0; p < 10; p++) begin
         if (p == 3) begin
            send_idle = 74;
            recv_idle = 31;
         end
         if (p == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_grid(plan[p]);
         gs = grid_now;
         cube = gs * gs * gs;
         offer_pixel('0, '0, '0, 1'b0);
         offer_pixel(ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off once per phase until the pipe is empty
            if (i == PHASE_ITEMS / 2) settle(0);
            if ($urandom_range(99) < 20) begin
               if ($urandom_range(9) == 0) begin
                  offer_load(ADDR_IN_W'($urandom_range(65535, LUT_ENTRIES)),
                             ENT_W'($urandom), ENT_W'($urandom), ENT_W'($urandom));
               end else begin
                  offer_load(ADDR_IN_W'($urandom_range(cube - 1)),
                             ENT_W'($urandom), ENT_W'($urandom), ENT_W'($urandom));
               end
            end else begin
               offer_pixel(pick_component(gs), pick_component(gs), pick_component(gs),
                           $urandom_range(7) == 0);
            end
         end
      end

      settle(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("lut3d_trilinear_apply_top verification clean");
      end else begin
         $display("lut3d_trilinear_apply_top verification failed");
      end
      $finish;
   end

endmodule
